>>> design/lr_pkg.sv
// ----------------------------------------------------------------------------
// Line rasteriser package
// Widths, codes, beat types and control bundles shared by the rasteriser.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned COORD_BITS = 6;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned PIX_W      = 6;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ACC_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned QUO_W      = FRAC_BITS + 1;
  localparam int unsigned ERR_W      = COORD_BITS + 3;
  localparam int unsigned DIV_CNT_W  = $clog2(ACC_W + 1);

  localparam logic [ACC_W-1:0] ACC_ONE  = ACC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W:0]   ACC_HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_DDA  = 2'd0,
    MODE_MID  = 2'd1,
    MODE_PAR  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 1'b0,
    CFG_COLOR = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [PIX_W-1:0] start_x;
    logic [PIX_W-1:0] start_y;
    logic [PIX_W-1:0] end_x;
    logic [PIX_W-1:0] end_y;
  } line_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pixel_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] num;
    logic [COORD_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   pos;
    logic signed [ERR_W-1:0] err;
  } par_t;

endpackage

>>> design/lr_div.sv
// ----------------------------------------------------------------------------
// Line rasteriser divider
// Restoring radix-2 divider, one quotient bit per cycle: (num << FRAC) / den.
// ----------------------------------------------------------------------------
module lr_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lr_pkg::div_req_t req_i,
  output lr_pkg::div_rsp_t rsp_o
);

  logic [lr_pkg::ACC_W-1:0]      sh_q, sh_d;
  logic [lr_pkg::COORD_BITS-1:0] rem_q, rem_d;
  logic [lr_pkg::COORD_BITS-1:0] den_q;
  logic [lr_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic                          done_q;
  logic [lr_pkg::COORD_BITS:0]   trial;
  logic [lr_pkg::COORD_BITS:0]   diff;
  logic                          ge;

  always_comb begin
    trial = {rem_q, sh_q[lr_pkg::ACC_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[lr_pkg::COORD_BITS-1:0] : trial[lr_pkg::COORD_BITS-1:0];
    sh_d  = {sh_q[lr_pkg::ACC_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == lr_pkg::DIV_CNT_W'(1));
      if (req_i.start) begin
        cnt_q <= lr_pkg::DIV_CNT_W'(lr_pkg::ACC_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - lr_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= {req_i.num, {lr_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (cnt_q != '0) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy = cnt_q != '0;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q[lr_pkg::QUO_W-1:0];

endmodule

>>> design/line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// Line rasteriser
// Emits every pixel of a line command by DDA, midpoint or parametric stepping.
// ----------------------------------------------------------------------------
// Use:
//   cfg channel: index 0 selects the mode (0 DDA, 1 midpoint, 2 parametric,
//   3 as DDA), index 1 sets the 24-bit colour. Write only while idle.
//   in channel: one beat is a line command with two endpoints.
//   out channel: one beat per pixel, last_pixel set on the final one.
//   n = max(|dx|,|dy|) steps give n + 1 beats, one per cycle unless stalled.
// Sequence:
//   midpoint and parametric: the command is registered, passes ST_SETUP,
//   and the first pixel is loaded into the output register in ST_EMIT.
//   DDA: the minor-axis increment comes from the serial divider, one bit
//   per cycle, while the block waits in ST_DIV between ST_SETUP and
//   ST_EMIT. A single-pixel DDA line skips the divider.
//   in_ready_o is high only between lines; the next command is taken while
//   the final pixel still sits in the output register.
// Reset: mode and colour clear to 0, the block goes idle, no pixel pending.
// Stall: generation pauses while the output register is full and not taken.
// ----------------------------------------------------------------------------
module line_rasterizer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lr_pkg::line_cmd_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lr_pkg::pixel_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lr_pkg::COLOR_W-1:0]   cfg_data_i
);

  lr_pkg::state_e                state_q, state_d;
  lr_pkg::mode_e                 mode_q;
  logic [lr_pkg::COLOR_W-1:0]    color_q;
  lr_pkg::line_cmd_t             cmd_q;
  lr_pkg::pixel_t                out_q;
  logic                          out_valid_q;
  logic [lr_pkg::COORD_BITS-1:0] cnt_q;
  logic [lr_pkg::COORD_BITS-1:0] n_q;
  logic [lr_pkg::COORD_BITS-1:0] minor_q;
  logic                          steep_q;
  logic                          up_q;
  logic                          minor_neg_q;
  logic [lr_pkg::COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic signed [lr_pkg::ERR_W-1:0] err_x_q, err_y_q;
  logic signed [lr_pkg::ERR_W-1:0] step_x_q, step_y_q;
  logic [lr_pkg::ACC_W-1:0]      acc_x_q, acc_y_q, inc_x_q, inc_y_q;

  lr_pkg::div_req_t              div_req;
  lr_pkg::div_rsp_t              div_rsp;

  logic                          in_acc, load, last, is_mid, is_par, dda_div;

  // setup decode
  logic [lr_pkg::COORD_BITS-1:0] x1, y1, x2, y2;
  logic signed [lr_pkg::COORD_BITS:0] sdx, sdy;
  logic [lr_pkg::COORD_BITS-1:0] adx, ady, n_c, dym_c;
  logic                          steep_c, rev_c;
  logic [lr_pkg::COORD_BITS-1:0] a1, b1, a2, b2, u0, v0, vend;
  logic signed [lr_pkg::ERR_W-1:0] d0, two_n, two_m;

  // pixel datapath
  logic [lr_pkg::ACC_W:0]        rnd_x, rnd_y;
  logic [lr_pkg::COORD_BITS-1:0] px, py;
  lr_pkg::par_t                  par_x, par_y;
  logic [lr_pkg::ACC_W-1:0]      quot_ext, minor_inc, major_pos, major_neg;

  function automatic lr_pkg::par_t par_step(
    input logic [lr_pkg::COORD_BITS-1:0]   pos,
    input logic signed [lr_pkg::ERR_W-1:0] err,
    input logic signed [lr_pkg::ERR_W-1:0] stp,
    input logic signed [lr_pkg::ERR_W-1:0] tn
  );
    logic signed [lr_pkg::ERR_W-1:0] r;
    lr_pkg::par_t                    res;
    r       = err + stp;
    res.pos = pos;
    res.err = r;
    if (r >= tn) begin
      res.err = r - tn;
      res.pos = pos + lr_pkg::COORD_BITS'(1);
    end else if (r[lr_pkg::ERR_W-1]) begin
      res.err = r + tn;
      res.pos = pos - lr_pkg::COORD_BITS'(1);
    end
    return res;
  endfunction

  lr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign is_mid = mode_q == lr_pkg::MODE_MID;
  assign is_par = mode_q == lr_pkg::MODE_PAR;

  always_comb begin
    x1    = cmd_q.start_x[lr_pkg::COORD_BITS-1:0];
    y1    = cmd_q.start_y[lr_pkg::COORD_BITS-1:0];
    x2    = cmd_q.end_x[lr_pkg::COORD_BITS-1:0];
    y2    = cmd_q.end_y[lr_pkg::COORD_BITS-1:0];
    sdx   = $signed({1'b0, x2}) - $signed({1'b0, x1});
    sdy   = $signed({1'b0, y2}) - $signed({1'b0, y1});
    adx   = sdx[lr_pkg::COORD_BITS] ? lr_pkg::COORD_BITS'(-sdx) : lr_pkg::COORD_BITS'(sdx);
    ady   = sdy[lr_pkg::COORD_BITS] ? lr_pkg::COORD_BITS'(-sdy) : lr_pkg::COORD_BITS'(sdy);
    steep_c = ady > adx;
    n_c   = steep_c ? ady : adx;
    dym_c = steep_c ? adx : ady;
    a1    = steep_c ? y1 : x1;
    b1    = steep_c ? x1 : y1;
    a2    = steep_c ? y2 : x2;
    b2    = steep_c ? x2 : y2;
    rev_c = a1 > a2;
    u0    = rev_c ? a2 : a1;
    v0    = rev_c ? b2 : b1;
    vend  = rev_c ? b1 : b2;
    d0    = $signed({2'b00, dym_c, 1'b0}) - $signed({3'b000, n_c});
    two_n = $signed({2'b00, n_q, 1'b0});
    two_m = $signed({2'b00, minor_q, 1'b0});
  end

  always_comb begin
    rnd_x     = {1'b0, acc_x_q} + lr_pkg::ACC_HALF;
    rnd_y     = {1'b0, acc_y_q} + lr_pkg::ACC_HALF;
    par_x     = par_step(pos_x_q, err_x_q, step_x_q, two_n);
    par_y     = par_step(pos_y_q, err_y_q, step_y_q, two_n);
    quot_ext  = lr_pkg::ACC_W'(div_rsp.quot);
    minor_inc = minor_neg_q ? lr_pkg::ACC_W'(0) - quot_ext : quot_ext;
    major_pos = lr_pkg::ACC_ONE;
    major_neg = lr_pkg::ACC_W'(0) - lr_pkg::ACC_ONE;
    if (is_mid) begin
      px = steep_q ? pos_y_q : pos_x_q;
      py = steep_q ? pos_x_q : pos_y_q;
    end else if (is_par) begin
      px = pos_x_q;
      py = pos_y_q;
    end else begin
      px = rnd_x[lr_pkg::FRAC_BITS +: lr_pkg::COORD_BITS];
      py = rnd_y[lr_pkg::FRAC_BITS +: lr_pkg::COORD_BITS];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lr_pkg::ST_IDLE:  if (in_valid_i) state_d = lr_pkg::ST_SETUP;
      lr_pkg::ST_SETUP: state_d = dda_div ? lr_pkg::ST_DIV : lr_pkg::ST_EMIT;
      lr_pkg::ST_DIV:   if (div_rsp.done) state_d = lr_pkg::ST_EMIT;
      lr_pkg::ST_EMIT:  if (load && last) state_d = lr_pkg::ST_IDLE;
      default:          state_d = lr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = state_q == lr_pkg::ST_IDLE;
    in_acc        = in_valid_i && in_ready_o;
    dda_div       = !is_mid && !is_par && (n_c != '0);
    div_req.start = (state_q == lr_pkg::ST_SETUP) && dda_div;
    div_req.num   = dym_c;
    div_req.den   = n_c;
    load          = (state_q == lr_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
    last          = cnt_q == n_q;
    cfg_ready_o   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= lr_pkg::MODE_DDA;
      color_q     <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == lr_pkg::ST_SETUP) begin
        cnt_q <= '0;
      end else if (load) begin
        cnt_q <= cnt_q + lr_pkg::COORD_BITS'(1);
      end
      if (cfg_valid_i) begin
        unique case (lr_pkg::cfg_idx_e'(cfg_idx_i))
          lr_pkg::CFG_MODE:  mode_q  <= lr_pkg::mode_e'(cfg_data_i[lr_pkg::MODE_W-1:0]);
          lr_pkg::CFG_COLOR: color_q <= cfg_data_i;
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_data_i;
    end
    if (state_q == lr_pkg::ST_SETUP) begin
      n_q         <= n_c;
      minor_q     <= dym_c;
      steep_q     <= steep_c;
      up_q        <= v0 < vend;
      minor_neg_q <= steep_c ? sdx[lr_pkg::COORD_BITS] : sdy[lr_pkg::COORD_BITS];
      step_x_q    <= $signed({sdx[lr_pkg::COORD_BITS], sdx, 1'b0});
      step_y_q    <= $signed({sdy[lr_pkg::COORD_BITS], sdy, 1'b0});
      acc_x_q     <= {x1, {lr_pkg::FRAC_BITS{1'b0}}};
      acc_y_q     <= {y1, {lr_pkg::FRAC_BITS{1'b0}}};
      inc_x_q     <= steep_c ? '0 : (sdx[lr_pkg::COORD_BITS] ? major_neg : major_pos);
      inc_y_q     <= steep_c ? (sdy[lr_pkg::COORD_BITS] ? major_neg : major_pos) : '0;
      if (is_mid) begin
        pos_x_q <= u0;
        pos_y_q <= v0;
        err_x_q <= d0;
      end else begin
        pos_x_q <= x1;
        pos_y_q <= y1;
        err_x_q <= $signed({3'b000, n_c});
        err_y_q <= $signed({3'b000, n_c});
      end
    end
    if ((state_q == lr_pkg::ST_DIV) && div_rsp.done) begin
      if (steep_q) begin
        inc_x_q <= minor_inc;
      end else begin
        inc_y_q <= minor_inc;
      end
    end
    if (load) begin
      out_q.pixel_x     <= lr_pkg::PIX_W'(px);
      out_q.pixel_y     <= lr_pkg::PIX_W'(py);
      out_q.pixel_color <= color_q;
      out_q.last_pixel  <= last;
      acc_x_q           <= acc_x_q + inc_x_q;
      acc_y_q           <= acc_y_q + inc_y_q;
      if (is_mid) begin
        pos_x_q <= pos_x_q + lr_pkg::COORD_BITS'(1);
        if (err_x_q > 0) begin
          pos_y_q <= up_q ? pos_y_q + lr_pkg::COORD_BITS'(1)
                          : pos_y_q - lr_pkg::COORD_BITS'(1);
          err_x_q <= err_x_q - two_n + two_m;
        end else begin
          err_x_q <= err_x_q + two_m;
        end
      end else if (is_par) begin
        pos_x_q <= par_x.pos;
        err_x_q <= par_x.err;
        pos_y_q <= par_y.pos;
        err_y_q <= par_y.err;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("command taken while a line is in progress");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last) |=> (state_q == lr_pkg::ST_IDLE))
    else $error("line did not end after its final pixel");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lr_pkg::ST_EMIT) |-> (cnt_q <= n_q))
    else $error("pixel count beyond line length");

endmodule

>>> dv/line_rasterizer_unit_tb.sv
// ----------------------------------------------------------------------------
// Line rasteriser testbench
// Sends line commands through the valid/ready input channel in all four
// modes and several colours. Every pixel beat is checked field by field
// against a behavioural rasteriser kept in the bench, or against the typed
// pixel of a single-pixel directed row. A directed table comes first, then
// random lines, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module line_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lr_pkg::*;

  localparam int          PERIOD      = 4;
  localparam int          RESET_CYC   = 12;
  localparam int          HOLD_CYC    = 300;
  localparam int          PHASES      = 6;
  localparam int          PHASE_LINES = 25;
  localparam int          DRAIN_CYC   = 40;
  localparam int          IDLE_CYC    = 8;
  localparam int          MAX_LINES   = 40;
  localparam longint      LIMIT       = 1_500_000;
  localparam logic [23:0] WHITE       = 24'hFF_FFFF;

  typedef struct packed {
    mode_e       mode;
    logic [23:0] color;
    line_cmd_t   cmd;
    logic        typed;
    pixel_t      want;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{MODE_DDA,  24'h0,     '{6'd0,  6'd0,  6'd0,  6'd0},  1'b1, '{6'd0, 6'd0, 24'h0, 1'b1}},
    '{MODE_DDA,  24'h0,     '{6'd0,  6'd0,  6'd63, 6'd63}, 1'b0, '0},
    '{MODE_DDA,  24'h0,     '{6'd63, 6'd0,  6'd0,  6'd63}, 1'b0, '0},
    '{MODE_DDA,  WHITE,     '{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{6'd63, 6'd63, WHITE, 1'b1}},
    '{MODE_DDA,  WHITE,     '{6'd5,  6'd10, 6'd40, 6'd17}, 1'b0, '0},
    '{MODE_DDA,  WHITE,     '{6'd40, 6'd17, 6'd5,  6'd10}, 1'b0, '0},
    '{MODE_MID,  24'hA5A5A5, '{6'd0,  6'd0,  6'd63, 6'd0},  1'b0, '0},
    '{MODE_MID,  24'hA5A5A5, '{6'd63, 6'd5,  6'd0,  6'd20}, 1'b0, '0},
    '{MODE_MID,  24'hA5A5A5, '{6'd10, 6'd0,  6'd20, 6'd63}, 1'b0, '0},
    '{MODE_MID,  24'hA5A5A5, '{6'd20, 6'd63, 6'd10, 6'd0},  1'b0, '0},
    '{MODE_MID,  24'hA5A5A5, '{6'd7,  6'd7,  6'd7,  6'd7},  1'b1,
      '{6'd7, 6'd7, 24'hA5A5A5, 1'b1}},
    '{MODE_PAR,  24'h5A5A5A, '{6'd0,  6'd63, 6'd63, 6'd0},  1'b0, '0},
    '{MODE_PAR,  24'h5A5A5A, '{6'd3,  6'd4,  6'd10, 6'd60}, 1'b0, '0},
    '{MODE_PAR,  24'h5A5A5A, '{6'd60, 6'd2,  6'd1,  6'd9},  1'b0, '0},
    '{MODE_PAR,  24'h5A5A5A, '{6'd33, 6'd33, 6'd33, 6'd33}, 1'b1,
      '{6'd33, 6'd33, 24'h5A5A5A, 1'b1}},
    '{MODE_RSVD, 24'h123456, '{6'd1,  6'd2,  6'd62, 6'd41}, 1'b0, '0},
    '{MODE_RSVD, 24'h123456, '{6'd0,  6'd63, 6'd63, 6'd63}, 1'b0, '0},
    '{MODE_DDA,  24'h123456, '{6'd0,  6'd0,  6'd3,  6'd1},  1'b0, '0},
    '{MODE_PAR,  24'h123456, '{6'd0,  6'd0,  6'd3,  6'd1},  1'b0, '0},
    '{MODE_MID,  24'h123456, '{6'd0,  6'd0,  6'd2,  6'd1},  1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  line_cmd_t   in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  pixel_t      out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_idx_i;
  logic [23:0] cfg_data_i;

  mode_e       cur_mode;
  logic [23:0] cur_color;
  pixel_t      pixels_due [$];
  int          mismatches;
  longint      cycles;
  bit          hold_req;

  line_rasterizer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic int mag(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void plot(input int x, input int y, input bit last);
    pixel_t p;
    p.pixel_x     = x[PIX_W-1:0];
    p.pixel_y     = y[PIX_W-1:0];
    p.pixel_color = cur_color;
    p.last_pixel  = last;
    pixels_due.push_back(p);
  endfunction

  function automatic int lerp_round(input int a, input int d, input int i, input int n);
    longint num;
    num = 2 * (longint'(a) * n + longint'(d) * i) + n;
    if (num < 0) num = 0;
    return int'(num / (2 * longint'(n)));
  endfunction

  // Appends every pixel of one line, in emission order, to pixels_due.
  function automatic void rasterise_line(input line_cmd_t cmd);
    int          x1, y1, x2, y2, dx, dy, n, t, d, ys, y, x;
    bit          steep;
    logic [63:0] half, mx, my, ix, iy, ax, ay;
    x1 = int'(cmd.start_x);
    y1 = int'(cmd.start_y);
    x2 = int'(cmd.end_x);
    y2 = int'(cmd.end_y);
    dx = x2 - x1;
    dy = y2 - y1;
    n  = mag(dx) > mag(dy) ? mag(dx) : mag(dy);
    case (cur_mode)
      MODE_MID: begin
        steep = mag(dy) > mag(dx);
        if (steep) begin
          t = x1; x1 = y1; y1 = t;
          t = x2; x2 = y2; y2 = t;
        end
        if (x1 > x2) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
        end
        dx = x2 - x1;
        dy = mag(y2 - y1);
        d  = 2 * dy - dx;
        ys = (y1 < y2) ? 1 : -1;
        y  = y1;
        for (x = x1; x <= x2; x++) begin
          if (steep) plot(y, x, x == x2);
          else plot(x, y, x == x2);
          if (d > 0) begin
            y += ys;
            d -= 2 * dx;
          end
          d += 2 * dy;
        end
      end
      MODE_PAR: begin
        if (n == 0) plot(x1, y1, 1'b1);
        else begin
          for (int i = 0; i <= n; i++)
            plot(lerp_round(x1, dx, i, n), lerp_round(y1, dy, i, n), i == n);
        end
      end
      default: begin
        if (n == 0) plot(x1, y1, 1'b1);
        else begin
          half = 64'd1 << (FRAC_BITS - 1);
          mx   = (64'(mag(dx)) << FRAC_BITS) / 64'(n);
          my   = (64'(mag(dy)) << FRAC_BITS) / 64'(n);
          ix   = dx < 0 ? 64'd0 - mx : mx;
          iy   = dy < 0 ? 64'd0 - my : my;
          ax   = 64'(x1) << FRAC_BITS;
          ay   = 64'(y1) << FRAC_BITS;
          for (int i = 0; i <= n; i++) begin
            plot(int'((ax + half) >> FRAC_BITS), int'((ay + half) >> FRAC_BITS), i == n);
            ax += ix;
            ay += iy;
          end
        end
      end
    endcase
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int near(input int c);
    int v;
    v = c + $urandom_range(0, 12) - 6;
    return v < 0 ? 0 : (v > 63 ? 63 : v);
  endfunction

  function automatic line_cmd_t rand_line();
    line_cmd_t c;
    int        sel;
    c   = line_cmd_t'($urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      c.end_x = c.start_x;
      c.end_y = c.start_y;
    end else if (sel == 1) begin
      c.start_x = {PIX_W{$urandom_range(0, 1) == 1}};
      c.start_y = {PIX_W{$urandom_range(0, 1) == 1}};
      c.end_x   = ~c.start_x;
      c.end_y   = $urandom_range(0, 1) ? c.start_y : ~c.start_y;
    end else if (sel > 4) begin
      c.end_x = PIX_W'(near(int'(c.start_x)));
      c.end_y = PIX_W'(near(int'(c.start_y)));
    end
    return c;
  endfunction

  // Leaves the input channel idle, waits for the block to drain, then writes.
  task automatic cfg_write(input cfg_idx_e idx, input logic [23:0] data);
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYC) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MODE) cur_mode = mode_e'(data[MODE_W-1:0]);
    else cur_color = data;
  endtask

  task automatic set_mode(input mode_e m);
    cfg_write(CFG_MODE, {22'($urandom), m});
  endtask

  task automatic push_line(input line_cmd_t cmd, input int gap, input bit typed,
                           input pixel_t want);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) pixels_due.push_back(want);
    else rasterise_line(cmd);
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat x=%0d y=%0d", out_data_o.pixel_x,
                                out_data_o.pixel_y));
      end else begin
        want = pixels_due.pop_front();
        if (out_data_o.pixel_x !== want.pixel_x)
          flag_mismatch($sformatf("pixel_x %0d, want %0d", out_data_o.pixel_x, want.pixel_x));
        if (out_data_o.pixel_y !== want.pixel_y)
          flag_mismatch($sformatf("pixel_y %0d, want %0d", out_data_o.pixel_y, want.pixel_y));
        if (out_data_o.pixel_color !== want.pixel_color)
          flag_mismatch($sformatf("pixel_color %h, want %h", out_data_o.pixel_color,
                                  want.pixel_color));
        if (out_data_o.last_pixel !== want.last_pixel)
          flag_mismatch($sformatf("last_pixel %b, want %b", out_data_o.last_pixel,
                                  want.last_pixel));
      end
    end
  end

  // Output back-pressure: calm stretches, stretches with gaps, one long hold-off.
  initial begin
    int  seg_len;
    bit  calm;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      seg_len = $urandom_range(20, 200);
      calm    = $urandom_range(0, 2) == 0;
      repeat (seg_len) begin
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYC) @(posedge clk_i);
        end else if (!calm && $urandom_range(0, 3) == 0) begin
          out_ready_i <= 1'b0;
          repeat (gap_len()) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    bit          send_calm;
    int          gap;
    mode_e       m;
    logic [23:0] col;
    cycles      = 0;
    mismatches  = 0;
    hold_req    = 1'b0;
    send_calm   = 1'b0;
    cur_mode    = MODE_DDA;
    cur_color   = '0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_idx_i   <= CFG_MODE;
    cfg_data_i  <= '0;
    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIR; r++) begin
      if (DIRECTED[r].mode != cur_mode) set_mode(DIRECTED[r].mode);
      if (DIRECTED[r].color != cur_color) cfg_write(CFG_COLOR, DIRECTED[r].color);
      push_line(DIRECTED[r].cmd, $urandom_range(0, 1) ? 0 : gap_len(), DIRECTED[r].typed,
                DIRECTED[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      m   = ph < 4 ? mode_e'(ph) : mode_e'($urandom_range(0, 3));
      col = ph == 0 ? WHITE : (ph == 1 ? 24'h0 : 24'($urandom));
      set_mode(m);
      cfg_write(CFG_COLOR, col);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < PHASE_LINES; k++) begin
        if ($urandom_range(0, 9) == 0) send_calm = !send_calm;
        gap = (send_calm || ph == 2 || $urandom_range(0, 1)) ? 0 : gap_len();
        push_line(rand_line(), gap, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
